// ===== sv/sgb_pkg.sv =====
// shared types, constants and font rom for the scaled glyph row blitter
// no dependencies
package sgb_pkg;

  localparam int FRAME_ROWS_DEF   = 240;
  localparam int FRAME_COLS_DEF   = 320;
  localparam int GLYPH_WIDTH_DEF  = 5;
  localparam int GLYPH_HEIGHT_DEF = 7;
  localparam int GLYPH_COUNT_DEF  = 9;
  localparam int MAX_RESULTS      = 45;
  localparam int ROM_SLOTS        = 9;
  localparam int ROM_ROWS         = 7;
  localparam int CW               = 13;
  localparam int AW               = 20;
  localparam int COLOR_W          = 12;
  localparam logic [1:0] SCALE_RESET = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_FLUSH
  } seq_state_t;

  typedef struct packed {
    logic          clear;
    logic          cand;
    logic          flush;
    logic [AW-1:0] addr;
  } emit_req_t;

  // slot from character code, digits only
  function automatic logic [3:0] slot_of(input logic [7:0] code);
    logic [7:0] d;
    d = code - 8'h30;
    if (code >= 8'h30 && code <= 8'h39) begin
      return d[3:0];
    end
    return 4'd0;
  endfunction

  function automatic logic [7:0] font_row(input logic [3:0] slot, input logic [2:0] row,
                                          input int glyph_count, input int glyph_height);
    logic [7:0] r;
    r = 8'h00;
    if (int'(slot) < glyph_count && int'(slot) < ROM_SLOTS &&
        int'(row) < glyph_height && int'(row) < ROM_ROWS) begin
      case (slot)
        4'd1: begin
          case (row)
            3'd3: r = 8'h1F;
            default: r = 8'h11;
          endcase
          if (row >= 3'd4) r = 8'h01;
        end
        4'd2: begin
          case (row)
            3'd0, 3'd6: r = 8'h1E;
            default: r = 8'h11;
          endcase
        end
        4'd3: begin
          case (row)
            3'd1: r = 8'h19;
            3'd2: r = 8'h15;
            3'd3: r = 8'h13;
            default: r = 8'h11;
          endcase
        end
        4'd4: begin
          case (row)
            3'd0, 3'd3: r = 8'h1E;
            3'd4: r = 8'h14;
            3'd5: r = 8'h12;
            default: r = 8'h11;
          endcase
        end
        4'd5: begin
          case (row)
            3'd0: r = 8'h00;
            3'd1, 3'd6: r = 8'h0E;
            3'd3: r = 8'h1F;
            3'd4: r = 8'h10;
            default: r = 8'h11;
          endcase
        end
        4'd6: begin
          case (row)
            3'd1: r = 8'h0F;
            3'd2: r = 8'h10;
            3'd3: r = 8'h0E;
            3'd4: r = 8'h01;
            3'd5: r = 8'h1E;
            default: r = 8'h00;
          endcase
        end
        4'd7: begin
          case (row)
            3'd1, 3'd5: r = 8'h11;
            3'd2, 3'd4: r = 8'h0A;
            3'd3: r = 8'h04;
            default: r = 8'h00;
          endcase
        end
        4'd8: begin
          case (row)
            3'd1, 3'd2, 3'd5: r = 8'h11;
            3'd3: r = 8'h0F;
            3'd4: r = 8'h01;
            3'd6: r = 8'h0E;
            default: r = 8'h00;
          endcase
        end
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== sv/scaled_glyph_row_blitter.sv =====
// scaled glyph row blitter: one glyph row in, one pixel write out per cycle at most
// busy while it loads the row, scans each column (a lit one square by square unless scale is zero) and flushes
// the sequencer steps one candidate pixel per cycle through its coordinate adders and clip compare
// each result appears in the cycle after the next candidate pixel is taken, the final one as busy falls
// results cannot be stalled; synchronous reset idles the block and sets the scale to 3
// uses sgb_pkg, sgb_seq, sgb_emit
module scaled_glyph_row_blitter #(
  parameter int FRAME_ROWS   = sgb_pkg::FRAME_ROWS_DEF,
  parameter int FRAME_COLS   = sgb_pkg::FRAME_COLS_DEF,
  parameter int GLYPH_WIDTH  = sgb_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_HEIGHT = sgb_pkg::GLYPH_HEIGHT_DEF,
  parameter int GLYPH_COUNT  = sgb_pkg::GLYPH_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_data,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [9:0]            x_origin,
  input  logic signed [9:0]            y_origin,
  input  logic [7:0]                   char_code,
  input  logic [2:0]                   glyph_row,
  input  logic [sgb_pkg::COLOR_W-1:0]  pixel_color,
  output logic                         out_valid,
  output logic [sgb_pkg::AW-1:0]       pixel_address,
  output logic [sgb_pkg::COLOR_W-1:0]  out_color,
  output logic                         last_pixel
);
  import sgb_pkg::*;

  logic [1:0]         pixel_scale;
  logic [COLOR_W-1:0] color;
  emit_req_t          req;

  assign cfg_ready = ~busy & ~start;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pixel_scale <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      color <= pixel_color;
    end
  end

  sgb_seq #(
    .FRAME_ROWS  (FRAME_ROWS),
    .FRAME_COLS  (FRAME_COLS),
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .GLYPH_HEIGHT(GLYPH_HEIGHT),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .scale    (pixel_scale),
    .x_origin (x_origin),
    .y_origin (y_origin),
    .char_code(char_code),
    .glyph_row(glyph_row),
    .busy     (busy),
    .req      (req)
  );

  sgb_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .color        (color),
    .out_valid    (out_valid),
    .pixel_address(pixel_address),
    .out_color    (out_color),
    .last_pixel   (last_pixel)
  );

endmodule

// ===== sv/sgb_seq.sv =====
// sequencer and coordinate stepper: walks the lit bits and scale squares of one glyph row
// separate adders step the pixel row and column, one clip compare per cycle; uses sgb_pkg
module sgb_seq #(
  parameter int FRAME_ROWS   = sgb_pkg::FRAME_ROWS_DEF,
  parameter int FRAME_COLS   = sgb_pkg::FRAME_COLS_DEF,
  parameter int GLYPH_WIDTH  = sgb_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_HEIGHT = sgb_pkg::GLYPH_HEIGHT_DEF,
  parameter int GLYPH_COUNT  = sgb_pkg::GLYPH_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [1:0]                scale,
  input  logic signed [9:0]         x_origin,
  input  logic signed [9:0]         y_origin,
  input  logic [7:0]                char_code,
  input  logic [2:0]                glyph_row,
  output logic                      busy,
  output sgb_pkg::emit_req_t        req
);
  import sgb_pkg::*;

  localparam int CLW = $clog2(GLYPH_WIDTH + 1);

  seq_state_t state, state_next;

  logic signed [CW-1:0]   cur_r, cur_r_next;
  logic signed [CW-1:0]   cur_c, cur_c_next;
  logic signed [CW-1:0]   col_base, col_base_next;
  logic signed [CW-1:0]   row_base;
  logic [GLYPH_WIDTH-1:0] bits_sr, bits_sr_next;
  logic [CLW-1:0]         col, col_next;
  logic [1:0]             sx, sx_next;
  logic [1:0]             sy, sy_next;
  logic [1:0]             s;
  logic [3:0]             slot;
  logic [2:0]             grow;
  logic signed [CW-1:0]   x0;
  logic signed [CW-1:0]   y0;
  logic [7:0]             rom_bits;
  logic signed [CW-1:0]   col_step;
  logic signed [CW-1:0]   load_row;
  logic [4:0]             row_off;
  logic                   in_frame;
  logic                   lit;
  logic                   col_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      s    <= scale;
      slot <= slot_of(char_code);
      grow <= glyph_row;
      x0   <= CW'(x_origin);
      y0   <= CW'(y_origin);
    end
    if (state == S_LOAD) begin
      row_base <= load_row;
    end
    cur_r    <= cur_r_next;
    cur_c    <= cur_c_next;
    col_base <= col_base_next;
    bits_sr  <= bits_sr_next;
    col      <= col_next;
    sx       <= sx_next;
    sy       <= sy_next;
  end

  assign rom_bits = font_row(slot, grow, GLYPH_COUNT, GLYPH_HEIGHT);
  assign row_off  = grow * s;
  assign load_row = y0 + CW'(row_off);
  assign col_step = col_base + CW'(s);
  assign lit      = bits_sr[GLYPH_WIDTH-1];
  assign col_done = (col == CLW'(GLYPH_WIDTH));
  assign in_frame = (cur_r >= 0) && (cur_r < CW'(FRAME_ROWS)) &&
                    (cur_c >= 0) && (cur_c < CW'(FRAME_COLS));

  always_comb begin
    state_next    = state;
    cur_r_next    = cur_r;
    cur_c_next    = cur_c;
    col_base_next = col_base;
    bits_sr_next  = bits_sr;
    col_next      = col;
    sx_next       = sx;
    sy_next       = sy;
    req.clear     = 1'b0;
    req.cand      = 1'b0;
    req.flush     = 1'b0;
    req.addr      = {cur_r[7:0], cur_c[11:0]};
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        req.clear     = 1'b1;
        bits_sr_next  = rom_bits[GLYPH_WIDTH-1:0];
        cur_r_next    = load_row;
        cur_c_next    = x0;
        col_base_next = x0;
        col_next      = '0;
        sx_next       = 2'd0;
        sy_next       = 2'd0;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (col_done) begin
          state_next = S_FLUSH;
        end else if (!lit || s == 2'd0) begin
          // unlit column or scale zero, move to the next
          col_next      = col + 1'b1;
          bits_sr_next  = bits_sr << 1;
          col_base_next = col_step;
          cur_c_next    = col_step;
          cur_r_next    = row_base;
        end else begin
          req.cand = in_frame;
          if (sx == s - 2'd1) begin
            sx_next = 2'd0;
            if (sy == s - 2'd1) begin
              sy_next       = 2'd0;
              col_next      = col + 1'b1;
              bits_sr_next  = bits_sr << 1;
              col_base_next = col_step;
              cur_c_next    = col_step;
              cur_r_next    = row_base;
            end else begin
              sy_next    = sy + 2'd1;
              cur_r_next = cur_r + CW'(1);
              cur_c_next = col_base;
            end
          end else begin
            sx_next    = sx + 2'd1;
            cur_c_next = cur_c + CW'(1);
          end
        end
      end
      S_FLUSH: begin
        req.flush  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  a_flush_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH |=> state == S_IDLE) else $error("flush did not end item");
  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && start |=> state == S_LOAD) else $error("start not taken");
  a_cand_scan: assert property (@(posedge clk) disable iff (rst)
    req.cand |-> state == S_SCAN && !col_done) else $error("candidate outside scan");
  a_no_cand_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && s == 2'd0 |-> !req.cand) else $error("pixel at scale zero");

endmodule

// ===== sv/sgb_emit.sv =====
// result stage: holds one found pixel back so the final write of an item can be flagged
// uses sgb_pkg
module sgb_emit (
  input  logic                         clk,
  input  logic                         rst,
  input  sgb_pkg::emit_req_t           req,
  input  logic [sgb_pkg::COLOR_W-1:0]  color,
  output logic                         out_valid,
  output logic [sgb_pkg::AW-1:0]       pixel_address,
  output logic [sgb_pkg::COLOR_W-1:0]  out_color,
  output logic                         last_pixel
);
  import sgb_pkg::*;

  localparam int NW = $clog2(MAX_RESULTS + 1);

  logic          pend_valid;
  logic [AW-1:0] pend_addr;
  logic [NW-1:0] count;
  logic          take;

  assign take = req.cand && (count < NW'(MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      count      <= '0;
      out_valid  <= 1'b0;
      last_pixel <= 1'b0;
    end else begin
      out_valid  <= 1'b0;
      last_pixel <= 1'b0;
      if (req.clear) begin
        pend_valid <= 1'b0;
        count      <= '0;
      end else if (take) begin
        count      <= count + 1'b1;
        pend_valid <= 1'b1;
        out_valid  <= pend_valid;
      end else if (req.flush) begin
        pend_valid <= 1'b0;
        out_valid  <= pend_valid;
        last_pixel <= pend_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take || req.flush) begin
      pixel_address <= pend_addr;
      out_color     <= color;
    end
    if (take) begin
      pend_addr <= req.addr;
    end
  end

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    last_pixel |-> out_valid) else $error("last flag without item");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(MAX_RESULTS)) else $error("result count past cap");
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    req.flush && pend_valid |=> out_valid && last_pixel) else $error("final item lost");
  a_take_holds: assert property (@(posedge clk) disable iff (rst)
    take |=> pend_valid) else $error("pixel not held");

endmodule
